>>> sv/itrs_pkg.sv
// Shared constants, types and helper functions of the radix text formatter.
package itrs_pkg;

  localparam int MAX_SYMBOLS     = 16;
  localparam int DIGIT_DEPTH     = 32;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int DIGIT_W         = 4;
  localparam int BASE_W          = 5;
  localparam int ALPHA_W         = 64;
  localparam int CHAR_W          = 8;
  localparam int CFG_IDX_W       = 2;
  localparam int RECIP_W         = 32;

  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA_LO = 2'd0,
    CFG_ALPHA_HI = 2'd1,
    CFG_BASE     = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PUSH_NONE,
    PUSH_SIGN,
    PUSH_ZERO,
    PUSH_DIGIT
  } push_e;

  typedef struct packed {
    logic [ALPHA_W-1:0] alpha_lo;
    logic [ALPHA_W-1:0] alpha_hi;
    logic [BASE_W-1:0]  base;
  } cfg_t;

  typedef struct packed {
    logic  load;
    logic  mul1;
    logic  mul2;
    logic  fix;
    logic  dec;
    push_e push;
  } cmd_t;

  typedef struct packed {
    logic mag_zero;
    logic q_zero;
    logic cnt_last_slot;
    logic cnt_one;
    logic neg;
    logic out_free;
    logic rem_ok;
  } status_t;

  // Symbols 0..7 live in the low word, 8..15 in the high word, lowest byte first.
  function automatic logic [CHAR_W-1:0] symbol_at(input cfg_t cfg,
                                                  input logic [DIGIT_W-1:0] idx);
    logic [ALPHA_W-1:0] word;
    word = idx[3] ? cfg.alpha_hi : cfg.alpha_lo;
    return word[{idx[2:0], 3'b000} +: CHAR_W];
  endfunction

  // Truncated reciprocal floor(2^32 / d); the quotient estimate it gives is at
  // most one below the true quotient.
  function automatic logic [RECIP_W-1:0] recip_of(input logic [BASE_W-1:0] base);
    logic [RECIP_W-1:0] r;
    case (base)
      5'd2:    r = 32'h8000_0000;
      5'd3:    r = 32'h5555_5555;
      5'd4:    r = 32'h4000_0000;
      5'd5:    r = 32'h3333_3333;
      5'd6:    r = 32'h2AAA_AAAA;
      5'd7:    r = 32'h2492_4924;
      5'd8:    r = 32'h2000_0000;
      5'd9:    r = 32'h1C71_C71C;
      5'd10:   r = 32'h1999_9999;
      5'd11:   r = 32'h1745_D174;
      5'd12:   r = 32'h1555_5555;
      5'd13:   r = 32'h13B1_3B13;
      5'd14:   r = 32'h1249_2492;
      5'd15:   r = 32'h1111_1111;
      5'd16:   r = 32'h1000_0000;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> sv/itrs_ifs.sv
// Valid/ready channel interfaces for the input value and the output characters.
interface itrs_in_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface itrs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;
  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

>>> sv/itrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module itrs_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/itrs_cfg.sv
// Configuration registers and the alphabet validity check.
module itrs_cfg import itrs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ALPHA_W-1:0]   cfg_data_i,
  output cfg_t                 cfg_o,
  output logic                 alpha_ok_o
);

  cfg_t cfg_q;
  logic bad;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ALPHA_LO: cfg_q.alpha_lo <= cfg_data_i;
        CFG_ALPHA_HI: cfg_q.alpha_hi <= cfg_data_i;
        CFG_BASE:     cfg_q.base     <= cfg_data_i[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  // Only symbols below the base count; every pair of them is compared.
  always_comb begin
    bad = (cfg_q.base < BASE_W'(2)) || (cfg_q.base > BASE_W'(MAX_SYMBOLS));
    for (int a = 0; a < 16; a++) begin
      if (BASE_W'(a) < cfg_q.base) begin
        if (symbol_at(cfg_q, DIGIT_W'(a)) == CHAR_PLUS ||
            symbol_at(cfg_q, DIGIT_W'(a)) == CHAR_MINUS) begin
          bad = 1'b1;
        end
        for (int b = a + 1; b < 16; b++) begin
          if (BASE_W'(b) < cfg_q.base &&
              symbol_at(cfg_q, DIGIT_W'(a)) == symbol_at(cfg_q, DIGIT_W'(b))) begin
            bad = 1'b1;
          end
        end
      end
    end
  end

  assign cfg_o      = cfg_q;
  assign alpha_ok_o = !bad;

endmodule

>>> sv/itrs_ctrl.sv
// Sequencer: digit extraction, then sign and digit characters out, or a lone zero.
module itrs_ctrl import itrs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    alpha_ok_i,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    in_ready_o
);

  typedef enum logic [3:0] {
    IDLE,
    START,
    MUL1,
    MUL2,
    FIX,
    SIGN,
    RD,
    DATA,
    ZERO
  } state_e;

  state_e state_q, state_d;
  cmd_t   cmd;

  always_comb begin
    state_d  = state_q;
    cmd      = '0;
    cmd.push = PUSH_NONE;
    case (state_q)
      IDLE: begin
        if (in_valid_i) begin
          cmd.load = 1'b1;
          // A word that arrives with a bad alphabet is taken and dropped.
          if (alpha_ok_i) begin
            state_d = START;
          end
        end
      end
      START: begin
        state_d = status_i.mag_zero ? ZERO : MUL1;
      end
      MUL1: begin
        cmd.mul1 = 1'b1;
        state_d  = MUL2;
      end
      MUL2: begin
        cmd.mul2 = 1'b1;
        state_d  = FIX;
      end
      FIX: begin
        cmd.fix = 1'b1;
        if (status_i.q_zero || status_i.cnt_last_slot) begin
          state_d = status_i.neg ? SIGN : RD;
        end else begin
          state_d = MUL1;
        end
      end
      SIGN: begin
        if (status_i.out_free) begin
          cmd.push = PUSH_SIGN;
          state_d  = RD;
        end
      end
      RD: begin
        state_d = DATA;
      end
      DATA: begin
        if (status_i.out_free) begin
          cmd.push = PUSH_DIGIT;
          cmd.dec  = 1'b1;
          state_d  = status_i.cnt_one ? IDLE : RD;
        end
      end
      ZERO: begin
        if (status_i.out_free) begin
          cmd.push = PUSH_ZERO;
          state_d  = IDLE;
        end
      end
      default: state_d = IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o      = cmd;
  assign in_ready_o = (state_q == IDLE);

endmodule

>>> sv/itrs_dp.sv
// Datapath: magnitude, reciprocal divider, digit store and output register.
module itrs_dp import itrs_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [VALUE_WIDTH-1:0] value_i,
  input  cfg_t                   cfg_i,
  input  cmd_t                   cmd_i,
  output status_t                status_o,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output logic [CHAR_W-1:0]      out_char_o,
  output logic                   out_last_o
);

  localparam int VW = VALUE_WIDTH;
  localparam int PW = VW + RECIP_W;
  localparam int BW = VW + BASE_W;
  localparam int AW = $clog2(DIGIT_DEPTH);
  localparam int CW = $clog2(DIGIT_DEPTH + 1);

  logic [VW-1:0]     mag_q, qest_q, mag_ld, quot;
  logic              neg_q;
  logic [PW-1:0]     prod_q;
  logic [BW-1:0]     back_q, rem_full, rem_fix, base_ext;
  logic [CW-1:0]     cnt_q, cnt_m1;
  logic              big;
  logic [DIGIT_W-1:0] rdata;
  logic              out_valid_q, out_last_q;
  logic [CHAR_W-1:0] out_char_q;
  logic              out_free;

  assign mag_ld   = value_i[VW-1] ? (~value_i + VW'(1)) : value_i;
  assign base_ext = BW'(cfg_i.base);
  assign rem_full = BW'(mag_q) - back_q;
  assign big      = (rem_full >= base_ext);
  assign rem_fix  = big ? (rem_full - base_ext) : rem_full;
  assign quot     = qest_q + VW'(big);
  assign cnt_m1   = cnt_q - CW'(1);
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.load) begin
      cnt_q <= '0;
    end else if (cmd_i.fix) begin
      cnt_q <= cnt_q + CW'(1);
    end else if (cmd_i.dec) begin
      cnt_q <= cnt_m1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_q <= mag_ld;
      neg_q <= value_i[VW-1];
    end else if (cmd_i.fix) begin
      mag_q <= quot;
    end
    if (cmd_i.mul1) begin
      prod_q <= PW'(mag_q) * PW'(recip_of(cfg_i.base));
    end
    if (cmd_i.mul2) begin
      qest_q <= prod_q[PW-1:RECIP_W];
      back_q <= BW'(prod_q[PW-1:RECIP_W]) * base_ext;
    end
  end

  itrs_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (DIGIT_DEPTH)
  ) u_digits (
    .clk_i   (clk_i),
    .we_i    (cmd_i.fix),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (rem_fix[DIGIT_W-1:0]),
    .raddr_i (cnt_m1[AW-1:0]),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push != PUSH_NONE) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.push)
      PUSH_SIGN: begin
        out_char_q <= CHAR_MINUS;
        out_last_q <= 1'b0;
      end
      PUSH_ZERO: begin
        out_char_q <= CHAR_ZERO;
        out_last_q <= 1'b1;
      end
      PUSH_DIGIT: begin
        out_char_q <= symbol_at(cfg_i, rdata);
        out_last_q <= (cnt_q == CW'(1));
      end
      default: ;
    endcase
  end

  assign status_o.mag_zero      = (mag_q == '0);
  assign status_o.q_zero        = (quot == '0);
  assign status_o.cnt_last_slot = (cnt_q == CW'(DIGIT_DEPTH - 1));
  assign status_o.cnt_one       = (cnt_q == CW'(1));
  assign status_o.neg           = neg_q;
  assign status_o.out_free      = out_free;
  assign status_o.rem_ok        = (rem_fix < base_ext);

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

endmodule

>>> sv/integer_to_radix_string.sv
// Top level: signed integer to text in a configured radix and alphabet.
//
// The input channel takes one signed word per item; the output channel gives
// one word per character, most significant digit first, with last set
// on the final character. A negative value starts with '-', zero gives '0'.
// Write alphabet_low, alphabet_high and base_size through the cfg port while
// the block is idle. With an invalid alphabet an item is taken and dropped.
// Each digit passes through three steps in the reciprocal divider (multiply by
// the truncated reciprocal, multiply back, correct the remainder); each
// character then passes through the RD and DATA states, as the digit store has
// a registered read, and waits in DATA while the output register is not free.
// The input is accepted only between items.
// Reset clears the configuration, so items are dropped until an alphabet and
// a base are written; the digit store needs no clearing pass. While the
// receiver stalls, the output register holds its word and the sequencer
// waits; the final word may still wait there while the next item is accepted.
module integer_to_radix_string import itrs_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ALPHA_W-1:0]   cfg_data_i,
  itrs_in_if.sink              in_ch,
  itrs_out_if.source           out_ch
);

  cfg_t    cfg;
  logic    alpha_ok;
  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  itrs_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg),
    .alpha_ok_o (alpha_ok)
  );

  itrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .alpha_ok_i (alpha_ok),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_ready_o (in_ready)
  );

  itrs_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (VALUE_WIDTH'(in_ch.value)),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_char_o  (out_ch.character),
    .out_last_o  (out_ch.last)
  );

  assign in_ch.ready = in_ready;

  // A word taken with a good alphabet starts a conversion, so the input closes.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ch.valid && in_ch.ready && alpha_ok) |=> !in_ch.ready)
    else $error("input still open after a conversion started");

  // The reciprocal estimate needs at most one correction step.
  a_digit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.fix |-> status.rem_ok)
    else $error("remainder not below the base after correction");

  // Characters are only loaded into a free output register.
  a_push_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.push != PUSH_NONE) |-> status.out_free)
    else $error("character pushed over a word still waiting");

endmodule

>>> dv/tb.sv
// Self-checking testbench for the signed integer to radix text formatter.
`timescale 1ns / 100ps

module tb;
  import itrs_pkg::*;

  localparam int DRAIN_CYCLES   = 200;
  localparam int WATCHDOG_LIMIT = 5000;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // Symbol 0 sits in the lowest byte of the low word, symbol 8 in that of the high word.
  localparam logic [ALPHA_W-1:0] DEC_LO    = 64'h3736_3534_3332_3130;
  localparam logic [ALPHA_W-1:0] DEC_HI    = 64'h0000_0000_0000_3938;
  localparam logic [ALPHA_W-1:0] HEX_HI    = 64'h4645_4443_4241_3938;
  localparam logic [ALPHA_W-1:0] PLUS_LO   = 64'h3736_3534_2B32_3130;
  localparam logic [ALPHA_W-1:0] DUP_HI    = 64'h3045_4443_4241_3938;
  localparam logic [ALPHA_W-1:0] ODD_LO    = 64'h2D2B_5A2D_2B41_005A;
  localparam logic [ALPHA_W-1:0] MINUS_LO  = 64'h2D2B_5A2D_2B2D_005A;
  localparam logic [ALPHA_W-1:0] ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum bit {STEP_CFG, STEP_ITEM} step_kind_e;

  typedef struct {
    step_kind_e           kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [ALPHA_W-1:0]   data;
    logic [31:0]          value;
    bit                   typed;
    string                text;
  } step_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } char_word_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [ALPHA_W-1:0]   cfg_data_i;

  itrs_in_if #(.W(32)) in_ch ();
  itrs_out_if          out_ch ();

  integer_to_radix_string #(.VALUE_WIDTH(32)) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  // Shadow copy of the configuration registers.
  logic [ALPHA_W-1:0] sym_lo;
  logic [ALPHA_W-1:0] sym_hi;
  logic [BASE_W-1:0]  radix_cfg;

  char_word_t pending_chars [$];
  int         mismatches;
  int         stalled_cycles;
  bit         idling;
  bit         quiet;

  // Directed part: rows with typed text are checked against that text,
  // the others against the predictor.
  step_t script [39] = '{
    '{STEP_ITEM, CFG_UNUSED,   64'd0,     32'd5,           1'b1, ""},
    '{STEP_CFG,  CFG_ALPHA_LO, DEC_LO,    32'd0,           1'b0, ""},
    '{STEP_CFG,  CFG_ALPHA_HI, DEC_HI,    32'd0,           1'b0, ""},
    '{STEP_CFG,  CFG_BASE,     64'd10,    32'd0,           1'b0, ""},
    '{STEP_ITEM, CFG_UNUSED,   64'd0,     32'd0,           1'b1, "0"},
    '{STEP_ITEM, CFG_UNUSED,   64'd0,     32'h7FFF_FFFF,   1'b1, "2147483647"},
    '{STEP_ITEM, CFG_UNUSED,   64'd0,     32'h8000_0000,   1'b1, "-2147483648"},
    '{STEP_ITEM, CFG_UNUSED,   64'd0,     32'hFFFF_FFFF,   1'b1, "-1"},
    '{STEP_ITEM, CFG_UNUSED,   64'd0,     32'd1234567,     1'b1, "1234567"},
    '{STEP_ITEM, CFG_UNUSED,   64'd0,     -32'sd987654,    1'b0, ""},
    '{STEP_CFG,  CFG_UNUSED,   ALL_ONES,  32'd0,           1'b0, ""},
    '{STEP_ITEM, CFG_UNUSED,   64'd0,     32'd42,          1'b1, "42"},
    '{STEP_CFG,  CFG_BASE,     64'd2,     32'd0,           1'b0, ""},
    '{STEP_ITEM, CFG_UNUSED,   64'd0,     32'h8000_0000,   1'b0, ""},
    '{STEP_ITEM, CFG_UNUSED,   64'd0,     32'h7FFF_FFFF,   1'b0, ""},
    '{STEP_CFG,  CFG_ALPHA_HI, HEX_HI,    32'd0,           1'b0, ""},
    '{STEP_CFG,  CFG_BASE,     64'd16,    32'd0,           1'b0, ""},
    '{STEP_ITEM, CFG_UNUSED,   64'd0,     32'h7FFF_FFFF,   1'b1, "7FFFFFFF"},
    '{STEP_ITEM, CFG_UNUSED,   64'd0,     32'h8000_0000,   1'b1, "-80000000"},
    '{STEP_ITEM, CFG_UNUSED,   64'd0,     32'hDEAD_BEEF,   1'b0, ""},
    '{STEP_CFG,  CFG_BASE,     64'd1,     32'd0,           1'b0, ""},
    '{STEP_ITEM, CFG_UNUSED,   64'd0,     32'd7,           1'b1, ""},
    '{STEP_ITEM, CFG_UNUSED,   64'd0,     32'd0,           1'b1, ""},
    '{STEP_CFG,  CFG_BASE,     64'd31,    32'd0,           1'b0, ""},
    '{STEP_ITEM, CFG_UNUSED,   64'd0,     32'd7,           1'b1, ""},
    '{STEP_CFG,  CFG_BASE,     64'd16,    32'd0,           1'b0, ""},
    '{STEP_CFG,  CFG_ALPHA_LO, PLUS_LO,   32'd0,           1'b0, ""},
    '{STEP_ITEM, CFG_UNUSED,   64'd0,     32'd9,           1'b1, ""},
    '{STEP_CFG,  CFG_ALPHA_LO, DEC_LO,    32'd0,           1'b0, ""},
    '{STEP_CFG,  CFG_ALPHA_HI, DUP_HI,    32'd0,           1'b0, ""},
    '{STEP_ITEM, CFG_UNUSED,   64'd0,     32'd9,           1'b1, ""},
    '{STEP_CFG,  CFG_BASE,     64'd15,    32'd0,           1'b0, ""},
    '{STEP_ITEM, CFG_UNUSED,   64'd0,     32'd1000,        1'b0, ""},
    '{STEP_CFG,  CFG_ALPHA_LO, ODD_LO,    32'd0,           1'b0, ""},
    '{STEP_CFG,  CFG_BASE,     64'd3,     32'd0,           1'b0, ""},
    '{STEP_ITEM, CFG_UNUSED,   64'd0,     32'd0,           1'b1, "0"},
    '{STEP_ITEM, CFG_UNUSED,   64'd0,     -32'sd5,         1'b0, ""},
    '{STEP_CFG,  CFG_ALPHA_LO, MINUS_LO,  32'd0,           1'b0, ""},
    '{STEP_ITEM, CFG_UNUSED,   64'd0,     32'd4,           1'b1, ""}
  };

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] idx);
    logic [ALPHA_W-1:0] word;
    word = idx[3] ? sym_hi : sym_lo;
    return word[idx[2:0] * CHAR_W +: CHAR_W];
  endfunction

  // Only the symbols in use are checked for signs and repeats.
  function automatic bit alphabet_usable();
    if (radix_cfg < 2 || radix_cfg > MAX_SYMBOLS) return 1'b0;
    for (int a = 0; a < radix_cfg; a++) begin
      if (glyph(DIGIT_W'(a)) == CHAR_PLUS || glyph(DIGIT_W'(a)) == CHAR_MINUS) return 1'b0;
      for (int b = a + 1; b < radix_cfg; b++)
        if (glyph(DIGIT_W'(b)) == glyph(DIGIT_W'(a))) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void push_char(input logic [CHAR_W-1:0] c, input logic last);
    char_word_t w;
    w.ch   = c;
    w.last = last;
    pending_chars.push_back(w);
  endfunction

  // Queues the characters that one value turns into under the current alphabet.
  function automatic void render_text(input logic [31:0] v);
    logic [31:0]        mag;
    logic [31:0]        radix;
    logic [DIGIT_W-1:0] digits [DIGIT_DEPTH];
    int                 n;
    if (!alphabet_usable()) return;
    radix = {27'd0, radix_cfg};
    mag   = v[31] ? (~v + 32'd1) : v;
    if (mag == 0) begin
      push_char(CHAR_ZERO, 1'b1);
      return;
    end
    n = 0;
    while (mag != 0) begin
      digits[n] = DIGIT_W'(mag % radix);
      mag       = mag / radix;
      n++;
    end
    if (v[31]) push_char(CHAR_MINUS, 1'b0);
    for (int k = n - 1; k >= 0; k--) push_char(glyph(digits[k]), k == 0);
  endfunction

  function automatic logic [31:0] rand_value();
    logic [31:0] v;
    int          sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      case ($urandom_range(0, 3))
        0:       v = 32'd0;
        1:       v = 32'h7FFF_FFFF;
        2:       v = 32'h8000_0000;
        default: v = 32'hFFFF_FFFF;
      endcase
    end else if (sel < 5) begin
      v = (sel < 3) ? 32'($urandom_range(0, 300)) : ($urandom >> $urandom_range(0, 31));
      if ($urandom_range(0, 1) == 1) v = -v;
    end else begin
      v = $urandom;
    end
    return v;
  endfunction

  // Draws 16 distinct symbols free of signs; a broken alphabet then gets one
  // defect among the symbols in use, or a radix out of range.
  function automatic void pick_alphabet(input bit broken, output logic [ALPHA_W-1:0] lo,
                                        output logic [ALPHA_W-1:0] hi,
                                        output logic [BASE_W-1:0] base);
    logic [CHAR_W-1:0] syms [MAX_SYMBOLS];
    logic [CHAR_W-1:0] s;
    bit                clash;
    int                spot;
    case ($urandom_range(0, 3))
      0:       base = 5'd2;
      1:       base = 5'd16;
      default: base = BASE_W'($urandom_range(2, 16));
    endcase
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      do begin
        s     = CHAR_W'($urandom_range(0, 255));
        clash = (s == CHAR_PLUS || s == CHAR_MINUS);
        for (int j = 0; j < i; j++)
          if (syms[j] == s) clash = 1'b1;
      end while (clash);
      syms[i] = s;
    end
    if (broken) begin
      case ($urandom_range(0, 3))
        0: syms[$urandom_range(0, base - 1)] = CHAR_PLUS;
        1: syms[$urandom_range(0, base - 1)] = CHAR_MINUS;
        2: begin
          spot       = $urandom_range(1, base - 1);
          syms[spot] = syms[$urandom_range(0, spot - 1)];
        end
        default: begin
          base = ($urandom_range(0, 1) == 1) ? BASE_W'($urandom_range(0, 1))
                                             : BASE_W'($urandom_range(17, 31));
        end
      endcase
    end
    for (int i = 0; i < 8; i++) begin
      lo[i * CHAR_W +: CHAR_W] = syms[i];
      hi[i * CHAR_W +: CHAR_W] = syms[i + 8];
    end
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ALPHA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_ALPHA_LO: sym_lo    = data;
      CFG_ALPHA_HI: sym_hi    = data;
      CFG_BASE:     radix_cfg = data[BASE_W-1:0];
      default: ;
    endcase
  endtask

  // Brings the block to rest: all expected words in, then enough cycles for a
  // dropped item to finish.
  task automatic settle();
    if (!quiet) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk_i); while (pending_chars.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clk_i);
      quiet = 1'b1;
    end
  endtask

  task automatic send_value(input logic [31:0] v, input bit typed, input string text);
    int gap;
    gap   = (idling && $urandom_range(0, 4) == 0) ? $urandom_range(1, 10) : 0;
    quiet = 1'b0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    do @(posedge clk_i); while (!in_ch.ready);
    if (typed) begin
      for (int i = 0; i < text.len(); i++) push_char(text[i], i == text.len() - 1);
    end else begin
      render_text(v);
    end
  endtask

  // Receiver: ready drops in bursts while idling is on.
  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left != 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (idling && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 9);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    char_word_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected word, expected none, got character %h last %b",
                 $time, out_ch.character, out_ch.last);
        mismatches++;
      end else begin
        want = pending_chars.pop_front();
        if (want.ch !== out_ch.character) begin
          $display("%0t: character mismatch, expected %h, got %h",
                   $time, want.ch, out_ch.character);
          mismatches++;
        end
        if (want.last !== out_ch.last) begin
          $display("%0t: last mismatch, expected %b, got %b", $time, want.last, out_ch.last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles == WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  initial begin
    logic [ALPHA_W-1:0] lo;
    logic [ALPHA_W-1:0] hi;
    logic [BASE_W-1:0]  base;
    bit                 broken;
    int                 n_items;
    mismatches     = 0;
    stalled_cycles = 0;
    quiet          = 1'b1;
    idling         = 1'b1;
    sym_lo         = '0;
    sym_hi         = '0;
    radix_cfg      = '0;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= '0;
    cfg_data_i  <= '0;
    in_ch.valid <= 1'b0;
    in_ch.value <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[r]) begin
      if (script[r].kind == STEP_CFG) begin
        settle();
        write_reg(script[r].reg_idx, script[r].data);
      end else begin
        send_value(script[r].value, script[r].typed, script[r].text);
      end
    end

    // Random phases, each with a fresh alphabet. Two carry broken alphabets,
    // and some run with both sides at full rate.
    for (int phase = 0; phase < 12; phase++) begin
      broken  = (phase == 4 || phase == 8);
      idling  = (phase % 4 != 2) && (phase != 11);
      n_items = broken ? 5 : 25;
      settle();
      pick_alphabet(broken, lo, hi, base);
      write_reg(CFG_ALPHA_LO, lo);
      write_reg(CFG_ALPHA_HI, hi);
      write_reg(CFG_BASE, {59'd0, base});
      for (int i = 0; i < n_items; i++) begin
        if (phase == 3 && i == 12) begin
          in_ch.valid <= 1'b0;
          do @(posedge clk_i); while (pending_chars.size() != 0);
        end
        send_value(rand_value(), 1'b0, "");
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
